// ===== src/uyvy2rgba_pkg.sv =====
`default_nettype none

package uyvy2rgba_pkg;

	localparam int CfgW    = 14;
	localparam int CfgIdxW = 2;
	localparam int AccW    = 20;

	localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CfgW-1:0] FRAME_WIDTH_RST  = 14'd1920;
	localparam logic [CfgW-1:0] FRAME_HEIGHT_RST = 14'd1080;

	localparam logic signed [AccW-1:0] COEF_Y     = 20'sd298;
	localparam logic signed [AccW-1:0] COEF_RV    = 20'sd409;
	localparam logic signed [AccW-1:0] COEF_GU    = 20'sd100;
	localparam logic signed [AccW-1:0] COEF_GV    = 20'sd208;
	localparam logic signed [AccW-1:0] COEF_BU    = 20'sd516;
	localparam logic signed [AccW-1:0] LUMA_OFS   = 20'sd16;
	localparam logic signed [AccW-1:0] CHROMA_OFS = 20'sd128;
	localparam logic signed [AccW-1:0] ROUND      = 20'sd128;
	localparam logic [7:0]             ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic [7:0] chroma_u;
		logic [7:0] luma_first;
		logic [7:0] chroma_v;
		logic [7:0] luma_second;
	} macropixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_of_item;
		logic       end_of_line;
		logic       end_of_frame;
	} pixel_t;

	typedef struct packed {
		logic two;
		logic row_end;
		logic frame_end;
	} pair_flags_t;

	function automatic logic [7:0] clamp_chan(input logic signed [AccW-1:0] acc);
		logic signed [AccW-1:0] sh;
		logic [7:0]             res;
		sh = acc >>> 8;
		if (sh < 0) begin
			res = 8'd0;
		end else if (sh > 255) begin
			res = 8'd255;
		end else begin
			res = sh[7:0];
		end
		return res;
	endfunction

	function automatic pixel_t make_pixel(
		input logic [7:0] luma,
		input logic [7:0] cb,
		input logic [7:0] cr,
		input logic       last_item,
		input logic       eol,
		input logic       eof
	);
		logic signed [AccW-1:0] c;
		logic signed [AccW-1:0] d;
		logic signed [AccW-1:0] e;
		pixel_t                 p;
		c = $signed({{(AccW-8){1'b0}}, luma}) - LUMA_OFS;
		d = $signed({{(AccW-8){1'b0}}, cb}) - CHROMA_OFS;
		e = $signed({{(AccW-8){1'b0}}, cr}) - CHROMA_OFS;
		p.red          = clamp_chan(COEF_Y * c + COEF_RV * e + ROUND);
		p.green        = clamp_chan(COEF_Y * c - COEF_GU * d - COEF_GV * e + ROUND);
		p.blue         = clamp_chan(COEF_Y * c + COEF_BU * d + ROUND);
		p.alpha        = ALPHA_OPAQUE;
		p.last_of_item = last_item;
		p.end_of_line  = eol;
		p.end_of_frame = eof;
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== src/uyvy2rgba_mp_if.sv =====
`default_nettype none

interface uyvy2rgba_mp_if
	import uyvy2rgba_pkg::*;
();
	logic        valid;
	logic        ready;
	macropixel_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/uyvy2rgba_px_if.sv =====
`default_nettype none

interface uyvy2rgba_px_if
	import uyvy2rgba_pkg::*;
();
	logic   valid;
	logic   ready;
	pixel_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/uyvy_to_rgba_converter.sv =====
// channel     | dir | payload
// ------------+-----+---------------------------------------------------------
// macropixel  | in  | chroma_u, luma_first, chroma_v, luma_second (8b each)
// pixel       | out | red, green, blue, alpha (8b), last_of_item, end_of_line,
//             |     | end_of_frame (1b)
// cfg         | in  | cfg_wr_en, cfg_index, cfg_wdata (frame_width, frame_height)
//
// a full pair is sent as two pixels in turn on the single pixel port; a pair
// cut short at the end of an odd-width row sends only its first pixel
// items are held in the item stage, pixels in the pixel output register
// arst_n clears counters, stage valids and loads the default frame size
// the item stage accepts a new item in the cycle its last pixel moves out, so
// pixel.ready low stalls the input only once the item stage is full
`default_nettype none

module uyvy_to_rgba_converter
	import uyvy2rgba_pkg::*;
#(
	parameter int MAX_WIDTH  = 8192,
	parameter int MAX_HEIGHT = 8192
) (
	input  wire                 clk,
	input  wire                 arst_n,
	uyvy2rgba_mp_if.sink        macropixel,
	uyvy2rgba_px_if.source      pixel,
	input  wire                 cfg_wr_en,
	input  wire [CfgIdxW-1:0]   cfg_index,
	input  wire [CfgW-1:0]      cfg_wdata
);

	localparam int ColW  = $clog2(MAX_WIDTH);
	localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WLim  = $clog2(MAX_WIDTH + 3);
	localparam int HLim  = $clog2(MAX_HEIGHT + 2);
	localparam int WCmpW = ((CfgW + 1) > WLim) ? (CfgW + 1) : WLim;
	localparam int HCmpW = ((CfgW + 1) > HLim) ? (CfgW + 1) : HLim;

	logic [CfgW-1:0]  frame_width_q;
	logic [CfgW-1:0]  frame_height_q;
	logic [ColW-1:0]  col_q;
	logic [RowW-1:0]  row_q;

	logic [WCmpW-1:0] w_raw;
	logic [WCmpW-1:0] w_eff;
	logic [HCmpW-1:0] h_raw;
	logic [HCmpW-1:0] h_eff;
	logic [WCmpW-1:0] col_ext;
	logic [HCmpW-1:0] row_ext;
	pair_flags_t      flags;

	macropixel_t      item_s1;
	pair_flags_t      flags_s1;
	logic             valid_s1;
	logic             phase_q;

	pixel_t           pix_q;
	logic             pix_valid_q;
	pixel_t           pix_next;
	logic             advance;
	logic             item_done;
	logic             in_accept;
	logic             last_pix;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective frame size and position flags
	always_comb begin
		w_raw   = WCmpW'(frame_width_q);
		h_raw   = HCmpW'(frame_height_q);
		if (w_raw == '0) begin
			w_eff = WCmpW'(1);
		end else if (w_raw > WCmpW'(MAX_WIDTH)) begin
			w_eff = WCmpW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw == '0) begin
			h_eff = HCmpW'(1);
		end else if (h_raw > HCmpW'(MAX_HEIGHT)) begin
			h_eff = HCmpW'(MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
		col_ext         = WCmpW'(col_q);
		row_ext         = HCmpW'(row_q);
		flags.two       = (col_ext + WCmpW'(1)) < w_eff;
		flags.row_end   = (col_ext + WCmpW'(2)) >= w_eff;
		flags.frame_end = flags.row_end && ((row_ext + HCmpW'(1)) >= h_eff);
	end

	// handshake and stage control
	always_comb begin
		last_pix         = phase_q || !flags_s1.two;
		advance          = valid_s1 && (!pix_valid_q || pixel.ready);
		item_done        = advance && last_pix;
		macropixel.ready = !valid_s1 || item_done;
		in_accept        = macropixel.valid && macropixel.ready;
		pix_next = make_pixel(phase_q ? item_s1.luma_second : item_s1.luma_first,
			item_s1.chroma_u, item_s1.chroma_v, last_pix,
			last_pix && flags_s1.row_end, last_pix && flags_s1.frame_end);
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (flags.row_end) begin
				col_q <= '0;
				row_q <= flags.frame_end ? '0 : RowW'(row_ext + HCmpW'(1));
			end else begin
				col_q <= ColW'(col_ext + WCmpW'(2));
			end
		end
	end

	// item stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (item_done) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= !last_pix;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1  <= macropixel.payload;
			flags_s1 <= flags;
		end
	end

	// pixel output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (advance) begin
			pix_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_q <= pix_next;
		end
	end

	assign pixel.valid   = pix_valid_q;
	assign pixel.payload = pix_q;

endmodule

`default_nettype wire
